// ===== sv/hvg_pkg.sv =====
package hvg_pkg;

    // Register map, word index on the configuration port
    localparam logic [2:0] REG_DEPTH_FLOOR    = 3'd0;
    localparam logic [2:0] REG_SEA_LEVEL      = 3'd1;
    localparam logic [2:0] REG_HEIGHT_CEILING = 3'd2;
    localparam logic [2:0] REG_HEIGHT_GAIN    = 3'd3;
    localparam logic [2:0] REG_X_STEP         = 3'd4;
    localparam logic [2:0] REG_Y_STEP         = 3'd5;
    localparam logic [2:0] REG_REGION_WIDTH   = 3'd6;
    localparam logic [2:0] REG_REGION_HEIGHT  = 3'd7;

    localparam logic [7:0]  RST_DEPTH_FLOOR    = 8'd0;
    localparam logic [7:0]  RST_SEA_LEVEL      = 8'd128;
    localparam logic [7:0]  RST_HEIGHT_CEILING = 8'd255;
    localparam logic [31:0] RST_STEP           = 32'd65536;
    localparam logic [12:0] RST_DIM            = 13'd256;

    // Direction component select
    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    // Top bit of the Q1.15 magnitude search
    localparam logic [3:0] Q_MSB = 4'd14;

    typedef enum logic [3:0] {
        MUL_NONE, MUL_Z, MUL_X, MUL_Y, MUL_SQX, MUL_SQY, MUL_SQZ,
        MUL_RX, MUL_RY, MUL_C2, MUL_PLO, MUL_PHI
    } mul_op_t;

    typedef enum logic [3:0] {
        WB_NONE, WB_PZ, WB_PX, WB_PY, WB_S_INIT, WB_S_ADD, WB_XM, WB_YM,
        WB_TGT, WB_ACC, WB_CMP, WB_DIR
    } wb_op_t;

    typedef struct packed {
        logic       cap;
        mul_op_t    mul;
        wb_op_t     wb;
        logic       minmax;
        logic       init_q;
        logic [1:0] comp;
        logic [3:0] bit_k;
        logic       load_out;
    } hvg_cmd_t;

    typedef struct packed {
        logic [7:0]  depth_floor;
        logic [7:0]  sea_level;
        logic [7:0]  height_ceiling;
        logic [31:0] height_gain;
        logic [31:0] x_step;
        logic [31:0] y_step;
        logic [12:0] region_width;
        logic [12:0] region_height;
    } hvg_cfg_t;

    // Saturated magnitude of a signed Q16.16 value given as sign and magnitude
    function automatic logic [31:0] sat_mag(input logic neg, input logic [63:0] v);
        logic [31:0] r;
        if (neg)
            r = (v >= 64'h8000_0000) ? 32'h8000_0000 : v[31:0];
        else
            r = (v > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : v[31:0];
        return r;
    endfunction

endpackage

// ===== sv/hvg_ctrl.sv =====
module hvg_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output hvg_pkg::hvg_cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_MZ, S_MX, S_MY, S_SQX, S_SQY, S_SQZ, S_RX, S_RY, S_RE,
        S_C2, S_TGT, S_PLO, S_PHI, S_CMP, S_CEND, S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] comp_reg, comp_next;
    logic [3:0] bit_reg, bit_next;
    logic       out_valid_reg, out_valid_next;
    logic       load;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign load      = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        comp_next      = comp_reg;
        bit_next       = bit_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.mul        = hvg_pkg::MUL_NONE;
        cmd.wb         = hvg_pkg::WB_NONE;
        cmd.comp       = comp_reg;
        cmd.bit_k      = bit_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap    = 1'b1;
                    state_next = S_MZ;
                end
            end
            S_MZ:
            begin
                cmd.mul    = hvg_pkg::MUL_Z;
                state_next = S_MX;
            end
            S_MX:
            begin
                cmd.mul    = hvg_pkg::MUL_X;
                cmd.wb     = hvg_pkg::WB_PZ;
                state_next = S_MY;
            end
            S_MY:
            begin
                cmd.mul    = hvg_pkg::MUL_Y;
                cmd.wb     = hvg_pkg::WB_PX;
                state_next = S_SQX;
            end
            S_SQX:
            begin
                cmd.mul    = hvg_pkg::MUL_SQX;
                cmd.wb     = hvg_pkg::WB_PY;
                cmd.minmax = 1'b1;
                state_next = S_SQY;
            end
            S_SQY:
            begin
                cmd.mul    = hvg_pkg::MUL_SQY;
                cmd.wb     = hvg_pkg::WB_S_INIT;
                state_next = S_SQZ;
            end
            S_SQZ:
            begin
                cmd.mul    = hvg_pkg::MUL_SQZ;
                cmd.wb     = hvg_pkg::WB_S_ADD;
                state_next = S_RX;
            end
            S_RX:
            begin
                cmd.mul    = hvg_pkg::MUL_RX;
                cmd.wb     = hvg_pkg::WB_S_ADD;
                state_next = S_RY;
            end
            S_RY:
            begin
                cmd.mul    = hvg_pkg::MUL_RY;
                cmd.wb     = hvg_pkg::WB_XM;
                state_next = S_RE;
            end
            S_RE:
            begin
                cmd.wb     = hvg_pkg::WB_YM;
                comp_next  = hvg_pkg::COMP_X;
                state_next = S_C2;
            end
            S_C2:
            begin
                cmd.mul    = hvg_pkg::MUL_C2;
                cmd.init_q = 1'b1;
                bit_next   = hvg_pkg::Q_MSB;
                state_next = S_TGT;
            end
            S_TGT:
            begin
                cmd.wb     = hvg_pkg::WB_TGT;
                state_next = S_PLO;
            end
            S_PLO:
            begin
                cmd.mul    = hvg_pkg::MUL_PLO;
                state_next = S_PHI;
            end
            S_PHI:
            begin
                cmd.mul    = hvg_pkg::MUL_PHI;
                cmd.wb     = hvg_pkg::WB_ACC;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.wb = hvg_pkg::WB_CMP;
                if (bit_reg == 4'd0)
                    state_next = S_CEND;
                else
                begin
                    bit_next   = bit_reg - 4'd1;
                    state_next = S_PLO;
                end
            end
            S_CEND:
            begin
                cmd.wb = hvg_pkg::WB_DIR;
                if (comp_reg == hvg_pkg::COMP_Z)
                    state_next = S_OUT;
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_C2;
                end
            end
            S_OUT:
            begin
                if (load)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            comp_reg      <= 2'd0;
            bit_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            comp_reg      <= comp_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/hvg_dp.sv =====
module hvg_dp
#(
    parameter int MAX_DIM = 4096
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  hvg_pkg::hvg_cfg_t  cfg,
    input  hvg_pkg::hvg_cmd_t  cmd,
    input  logic [7:0]         pixel,
    output logic [31:0]        pos_x,
    output logic [31:0]        pos_y,
    output logic [31:0]        pos_z,
    output logic [15:0]        dir_x,
    output logic [15:0]        dir_y,
    output logic [15:0]        dir_z,
    output logic [31:0]        z_low,
    output logic [31:0]        z_high,
    output logic [30:0]        bound_radius,
    output logic               last
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int DW = CW + 1;
    localparam int HW = CW + 2;

    // counters and running extremes
    logic [CW-1:0]      col_reg, row_reg;
    logic signed [31:0] min_reg, max_reg;

    // per-item working registers
    logic [7:0]  mz_reg;
    logic        nz_reg, nx_reg, ny_reg, last_reg;
    logic [HW-1:0] hx_reg, hy_reg;
    logic [DW-1:0] w_reg, h_reg;
    logic [63:0] mul_reg;
    logic [31:0] magx_reg, magy_reg, magz_reg;
    logic [63:0] s_reg;
    logic [30:0] xm_reg, ym_reg;
    logic [93:0] tgt_reg;
    logic [61:0] acc_reg;
    logic [14:0] q_reg;
    logic [29:0] qq_reg;
    logic [15:0] dx_reg, dy_reg, dz_reg;

    // output word
    logic [31:0] opx_reg, opy_reg, opz_reg, olow_reg, ohigh_reg;
    logic [15:0] odx_reg, ody_reg, odz_reg;
    logic [30:0] orad_reg;
    logic        olast_reg;

    logic [DW-1:0] w_eff, h_eff, w_lst, h_lst;
    logic          end_row, end_reg;
    logic [CW-1:0] col_e, row_e;
    logic signed [HW-1:0] hx_s, hy_s;
    logic [7:0]    pc;
    logic [8:0]    d9;
    logic [31:0]   mul_a, mul_b, magc;
    logic [29:0]   tt;
    logic [14:0]   bitm;
    logic [93:0]   full;
    logic signed [31:0] px_v, py_v, pz_v;
    logic [30:0]   rad_xy, rad;
    logic          negc;

    always_comb
    begin
        if (cfg.region_width == 13'd0)
            w_eff = DW'(1);
        else if (32'(cfg.region_width) > MAX_DIM)
            w_eff = DW'(MAX_DIM);
        else
            w_eff = DW'(cfg.region_width);
        if (cfg.region_height == 13'd0)
            h_eff = DW'(1);
        else if (32'(cfg.region_height) > MAX_DIM)
            h_eff = DW'(MAX_DIM);
        else
            h_eff = DW'(cfg.region_height);
        w_lst   = w_eff - DW'(1);
        h_lst   = h_eff - DW'(1);
        end_row = ({1'b0, col_reg} >= w_lst);
        end_reg = end_row && ({1'b0, row_reg} >= h_lst);
        col_e   = end_row ? w_lst[CW-1:0] : col_reg;
        row_e   = ({1'b0, row_reg} >= h_lst) ? h_lst[CW-1:0] : row_reg;
        hx_s    = $signed({1'b0, col_e, 1'b0}) - $signed({1'b0, w_eff});
        hy_s    = $signed({1'b0, row_e, 1'b0}) - $signed({1'b0, h_eff});

        // floor test first, then ceiling
        if (pixel < cfg.depth_floor)
            pc = cfg.depth_floor;
        else if (pixel > cfg.height_ceiling)
            pc = cfg.height_ceiling;
        else
            pc = pixel;
        d9 = {1'b0, pc} - {1'b0, cfg.sea_level};
    end

    assign px_v = nx_reg ? $signed(32'd0 - magx_reg) : $signed(magx_reg);
    assign py_v = ny_reg ? $signed(32'd0 - magy_reg) : $signed(magy_reg);
    assign pz_v = nz_reg ? $signed(32'd0 - magz_reg) : $signed(magz_reg);

    // trial square (q + 2^k)^2 built from the running q^2
    assign bitm = 15'd1 << cmd.bit_k;
    assign tt   = qq_reg + ({15'd0, q_reg} << (cmd.bit_k + 4'd1))
                + (30'd1 << {cmd.bit_k, 1'b0});
    assign full = {32'd0, acc_reg} + ({32'd0, mul_reg[61:0]} << 32);

    always_comb
    begin
        case (cmd.comp)
            hvg_pkg::COMP_X:
            begin
                magc = magx_reg;
                negc = nx_reg;
            end
            hvg_pkg::COMP_Y:
            begin
                magc = magy_reg;
                negc = ny_reg;
            end
            default:
            begin
                magc = magz_reg;
                negc = nz_reg;
            end
        endcase
    end

    // shared 32x32 multiplier operand select
    always_comb
    begin
        case (cmd.mul)
            hvg_pkg::MUL_Z:
            begin
                mul_a = {24'd0, mz_reg};
                mul_b = cfg.height_gain;
            end
            hvg_pkg::MUL_X:
            begin
                mul_a = 32'(hx_reg);
                mul_b = cfg.x_step;
            end
            hvg_pkg::MUL_Y:
            begin
                mul_a = 32'(hy_reg);
                mul_b = cfg.y_step;
            end
            hvg_pkg::MUL_SQX:
            begin
                mul_a = magx_reg;
                mul_b = magx_reg;
            end
            hvg_pkg::MUL_SQY:
            begin
                mul_a = magy_reg;
                mul_b = magy_reg;
            end
            hvg_pkg::MUL_SQZ:
            begin
                mul_a = magz_reg;
                mul_b = magz_reg;
            end
            hvg_pkg::MUL_RX:
            begin
                mul_a = 32'(w_reg);
                mul_b = cfg.x_step;
            end
            hvg_pkg::MUL_RY:
            begin
                mul_a = 32'(h_reg);
                mul_b = cfg.y_step;
            end
            hvg_pkg::MUL_C2:
            begin
                mul_a = magc;
                mul_b = magc;
            end
            hvg_pkg::MUL_PLO:
            begin
                mul_a = {2'b00, tt};
                mul_b = s_reg[31:0];
            end
            hvg_pkg::MUL_PHI:
            begin
                mul_a = {2'b00, tt};
                mul_b = s_reg[63:32];
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    always_comb
    begin
        rad_xy = (xm_reg > ym_reg) ? xm_reg : ym_reg;
        rad    = (max_reg[30:0] > rad_xy) ? max_reg[30:0] : rad_xy;
    end

    // control state: counters and running extremes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            min_reg <= '0;
            max_reg <= '0;
        end
        else
        begin
            if (cmd.cap)
            begin
                if (end_reg)
                begin
                    col_reg <= '0;
                    row_reg <= '0;
                end
                else if (end_row)
                begin
                    col_reg <= '0;
                    row_reg <= row_e + CW'(1);
                end
                else
                    col_reg <= col_e + CW'(1);
            end
            if (cmd.minmax)
            begin
                if (pz_v < min_reg)
                    min_reg <= pz_v;
                if (pz_v > max_reg)
                    max_reg <= pz_v;
            end
            // drop the extremes once the region's last word is out
            if (cmd.load_out && last_reg)
            begin
                min_reg <= '0;
                max_reg <= '0;
            end
        end
    end

    // datapath payload
    always_ff @(posedge clk)
    begin
        mul_reg <= 64'(mul_a) * 64'(mul_b);

        if (cmd.cap)
        begin
            nz_reg   <= d9[8];
            mz_reg   <= d9[8] ? 8'(9'd0 - d9) : d9[7:0];
            nx_reg   <= hx_s[HW-1];
            ny_reg   <= hy_s[HW-1];
            hx_reg   <= hx_s[HW-1] ? HW'(-hx_s) : HW'(hx_s);
            hy_reg   <= hy_s[HW-1] ? HW'(-hy_s) : HW'(hy_s);
            w_reg    <= w_eff;
            h_reg    <= h_eff;
            last_reg <= end_reg;
        end

        if (cmd.init_q)
        begin
            q_reg  <= '0;
            qq_reg <= '0;
        end

        case (cmd.wb)
            hvg_pkg::WB_PZ:     magz_reg <= hvg_pkg::sat_mag(nz_reg, mul_reg);
            hvg_pkg::WB_PX:     magx_reg <= hvg_pkg::sat_mag(nx_reg, mul_reg >> 1);
            hvg_pkg::WB_PY:     magy_reg <= hvg_pkg::sat_mag(ny_reg, mul_reg >> 1);
            hvg_pkg::WB_S_INIT: s_reg    <= mul_reg;
            hvg_pkg::WB_S_ADD:  s_reg    <= s_reg + mul_reg;
            hvg_pkg::WB_XM:     xm_reg   <= 31'(hvg_pkg::sat_mag(1'b0, mul_reg >> 1));
            hvg_pkg::WB_YM:     ym_reg   <= 31'(hvg_pkg::sat_mag(1'b0, mul_reg >> 1));
            hvg_pkg::WB_TGT:    tgt_reg  <= 94'(mul_reg) << 30;
            hvg_pkg::WB_ACC:    acc_reg  <= mul_reg[61:0];
            hvg_pkg::WB_CMP:
            begin
                // keep the trial bit while (q^2) * s stays within c^2 * 2^30
                if (full <= tgt_reg)
                begin
                    q_reg  <= q_reg | bitm;
                    qq_reg <= tt;
                end
            end
            hvg_pkg::WB_DIR:
            begin
                case (cmd.comp)
                    hvg_pkg::COMP_X:
                        dx_reg <= (s_reg == 64'd0) ? 16'd0
                                : (negc ? 16'd0 - {1'b0, q_reg} : {1'b0, q_reg});
                    hvg_pkg::COMP_Y:
                        dy_reg <= (s_reg == 64'd0) ? 16'd0
                                : (negc ? 16'd0 - {1'b0, q_reg} : {1'b0, q_reg});
                    default:
                        dz_reg <= (s_reg == 64'd0) ? 16'd0
                                : (negc ? 16'd0 - {1'b0, q_reg} : {1'b0, q_reg});
                endcase
            end
            default:
            begin
            end
        endcase

        if (cmd.load_out)
        begin
            opx_reg   <= px_v;
            opy_reg   <= py_v;
            opz_reg   <= pz_v;
            odx_reg   <= dx_reg;
            ody_reg   <= dy_reg;
            odz_reg   <= dz_reg;
            olow_reg  <= min_reg;
            ohigh_reg <= max_reg;
            orad_reg  <= last_reg ? rad : 31'd0;
            olast_reg <= last_reg;
        end
    end

    assign pos_x        = opx_reg;
    assign pos_y        = opy_reg;
    assign pos_z        = opz_reg;
    assign dir_x        = odx_reg;
    assign dir_y        = ody_reg;
    assign dir_z        = odz_reg;
    assign z_low        = olow_reg;
    assign z_high       = ohigh_reg;
    assign bound_radius = orad_reg;
    assign last         = olast_reg;

endmodule

// ===== sv/heightmap_vertex_generator.sv =====
// Heightmap vertex generator. Height pixels stream in on the s_ side in row
// order, region_width pixels per row, region_height rows per region; one
// vertex word leaves on the m_ side per pixel, with m_tlast on the region's
// final vertex. For each accepted pixel, one shared 32x32 multiplier forms
// z, x, y, the squared length and the half extents in nine steps, then the
// three Q1.15 direction components are found by a 15-bit magnitude search
// each (a setup that squares the component and forms the target, two
// multiplier passes and a compare per bit, a store of the component), and
// the result register is loaded as soon as it is free. s_tready is high only
// while the engine is idle, so a new pixel is taken only once the previous
// one has been loaded into the output register; a finished word waits in the
// output register, so the next pixel may be taken while the previous word is
// still stalled downstream. Configure the registers over the APB port only
// between regions or while idle.
module heightmap_vertex_generator
#(
    parameter int MAX_DIM = 4096
)
(
    input  logic         clk,
    input  logic         rst_n,

    // pixel stream; tdata: pixel[7:0]
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,

    // vertex stream; tdata from bit 0: pos_x[31:0], pos_y[31:0], pos_z[31:0],
    // dir_x[15:0], dir_y[15:0], dir_z[15:0], z_low[31:0], z_high[31:0],
    // bound_radius[30:0], one zero pad bit
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [239:0] m_tdata,
    output logic         m_tlast,

    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    hvg_pkg::hvg_cfg_t cfg_reg;
    hvg_pkg::hvg_cmd_t cmd;
    logic              wr_en;

    logic [31:0] pos_x, pos_y, pos_z, z_low, z_high;
    logic [15:0] dir_x, dir_y, dir_z;
    logic [30:0] bound_radius;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.depth_floor    <= hvg_pkg::RST_DEPTH_FLOOR;
            cfg_reg.sea_level      <= hvg_pkg::RST_SEA_LEVEL;
            cfg_reg.height_ceiling <= hvg_pkg::RST_HEIGHT_CEILING;
            cfg_reg.height_gain    <= hvg_pkg::RST_STEP;
            cfg_reg.x_step         <= hvg_pkg::RST_STEP;
            cfg_reg.y_step         <= hvg_pkg::RST_STEP;
            cfg_reg.region_width   <= hvg_pkg::RST_DIM;
            cfg_reg.region_height  <= hvg_pkg::RST_DIM;
        end
        else if (wr_en)
        begin
            case (paddr[4:2])
                hvg_pkg::REG_DEPTH_FLOOR:    cfg_reg.depth_floor    <= pwdata[7:0];
                hvg_pkg::REG_SEA_LEVEL:      cfg_reg.sea_level      <= pwdata[7:0];
                hvg_pkg::REG_HEIGHT_CEILING: cfg_reg.height_ceiling <= pwdata[7:0];
                hvg_pkg::REG_HEIGHT_GAIN:    cfg_reg.height_gain    <= pwdata;
                hvg_pkg::REG_X_STEP:         cfg_reg.x_step         <= pwdata;
                hvg_pkg::REG_Y_STEP:         cfg_reg.y_step         <= pwdata;
                hvg_pkg::REG_REGION_WIDTH:   cfg_reg.region_width   <= pwdata[12:0];
                hvg_pkg::REG_REGION_HEIGHT:  cfg_reg.region_height  <= pwdata[12:0];
                default:
                begin
                end
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (paddr[4:2])
            hvg_pkg::REG_DEPTH_FLOOR:    prdata = {24'd0, cfg_reg.depth_floor};
            hvg_pkg::REG_SEA_LEVEL:      prdata = {24'd0, cfg_reg.sea_level};
            hvg_pkg::REG_HEIGHT_CEILING: prdata = {24'd0, cfg_reg.height_ceiling};
            hvg_pkg::REG_HEIGHT_GAIN:    prdata = cfg_reg.height_gain;
            hvg_pkg::REG_X_STEP:         prdata = cfg_reg.x_step;
            hvg_pkg::REG_Y_STEP:         prdata = cfg_reg.y_step;
            hvg_pkg::REG_REGION_WIDTH:   prdata = {19'd0, cfg_reg.region_width};
            hvg_pkg::REG_REGION_HEIGHT:  prdata = {19'd0, cfg_reg.region_height};
            default:                     prdata = 32'd0;
        endcase
    end

    hvg_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd)
    );

    hvg_dp #(.MAX_DIM(MAX_DIM)) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .cmd          (cmd),
        .pixel        (s_tdata),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .dir_x        (dir_x),
        .dir_y        (dir_y),
        .dir_z        (dir_z),
        .z_low        (z_low),
        .z_high       (z_high),
        .bound_radius (bound_radius),
        .last         (m_tlast)
    );

    assign m_tdata = {1'b0, bound_radius, z_high, z_low, dir_z, dir_y, dir_x,
                      pos_z, pos_y, pos_x};

endmodule
